// File: hw/rtl/cartridge_bank_controller_rtc_unit_macros.svh
// assertion macros shared by the bank controller rtl
`ifndef CARTRIDGE_BANK_CONTROLLER_RTC_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_RTC_UNIT_MACROS_SVH

// condition implies expression in the same cycle
`define CBC_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// condition implies expression in the next cycle
`define CBC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// File: hw/rtl/cbcrtc_pkg.sv
// shared types, codes and constants of the bank controller
`default_nettype none

package cbcrtc_pkg;

   localparam int ROM_BANK_BYTES = 16384;
   localparam int RAM_BANK_BYTES = 8192;
   localparam int RAM_BANK_CNT   = 4;

   localparam int ROM_OFF_W  = $clog2(ROM_BANK_BYTES);
   localparam int RAM_OFF_W  = $clog2(RAM_BANK_BYTES);
   localparam int BANK_W     = 7;
   localparam int COUNT_W    = 8;
   localparam int SEL_W      = 4;
   localparam int RAM_SEL_W  = 2;
   localparam int PHYS_W     = 21;
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 16;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int RTC_REGS   = 5;
   localparam int RTC_IDX_W  = 3;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // remainder unit split: upper bank bits in the load cycle, the rest in the following cycle
   localparam int MOD_HI_BITS = 4;
   localparam int MOD_LO_BITS = BANK_W - MOD_HI_BITS;

   localparam logic [3:0]        RAM_ENABLE_KEY = 4'hA;
   localparam logic [SEL_W-1:0]  SEL_MODULUS    = 4'hD;
   localparam logic [SEL_W-1:0]  SEL_RTC_FIRST  = 4'h8;
   localparam logic [SEL_W-1:0]  SEL_RAM_LIMIT  = 4'h4;
   localparam logic [BYTE_W-1:0] OPEN_BUS_BYTE  = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_CTRL_WRITE = 2'd0,
      OP_ROM_READ   = 2'd1,
      OP_RAM_WRITE  = 2'd2,
      OP_RAM_READ   = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE      = 3'd0,
      KIND_ROM_READ  = 3'd1,
      KIND_RAM_READ  = 3'd2,
      KIND_RAM_WRITE = 3'd3,
      KIND_RTC_READ  = 3'd4
   } kind_type;

   // control write regions, decoded from addr[15:13]
   localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
   localparam logic [2:0] REGION_WINDOW_SEL = 3'd2;
   localparam logic [2:0] REGION_LATCH      = 3'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_HAS_RAM        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_RTC        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_BANK_COUNT = 2'd2;

   typedef struct packed {
      logic load_in;
      logic load_out;
   } cmd_type;

   // ram bank number folded onto the banks that exist
   function automatic logic [RAM_SEL_W-1:0] ram_bank_of(input logic [RAM_SEL_W-1:0] sel);
      int r;
      r = int'(sel);
      for (int k = 0; k < 4; k++) begin
         if (r >= RAM_BANK_CNT) begin
            r = r - RAM_BANK_CNT;
         end
      end
      return RAM_SEL_W'(r);
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cartridge_bank_controller_rtc_unit.sv
// top level of the cartridge bank controller with clock registers
// usage:
//   req channel carries one bus access per transfer: control write, rom read,
//   ram window write or ram window read. each access gives exactly one transfer
//   on the rsp channel with the access kind, physical address and data byte.
//   csr port writes has_ram (0), has_rtc (1) and rom_bank_count (2); the user must
//   write them only while no access is in flight, the block does not enforce this.
// timing:
//   an accepted access is captured and the controller moves to calc, where the
//   result is loaded into the output register, raising rsp_tvalid; the rom bank
//   remainder is split in the remainder unit (upper bits in the accept cycle,
//   lower bits in the next). req_tready is low in calc, so a new access is only
//   taken once the last result has been loaded into the output register.
// stall:
//   the result sits in an output register; a new access is accepted while it
//   waits, and its result is held back until rsp_tready takes the old one.
// reset:
//   synchronous; ram disabled, rom bank 1, window select 0, latch bit 0, all
//   clock bytes zero, has_ram and has_rtc set, rom_bank_count 128.
`default_nettype none

module cartridge_bank_controller_rtc_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // op[1:0], addr[17:2], data[25:18], zero fill [31:26]
   input  wire logic [cbcrtc_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // access_kind[2:0], phys_address[23:3], write_data[31:24], read_data[39:32]
   output logic      [cbcrtc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [cbcrtc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cbcrtc_pkg::COUNT_W-1:0]       csr_wdata
);

   cbcrtc_pkg::cmd_type                  cmd;
   logic [cbcrtc_pkg::KIND_W-1:0]        rsp_access_kind;
   logic [cbcrtc_pkg::PHYS_W-1:0]        rsp_phys_address;
   logic [cbcrtc_pkg::BYTE_W-1:0]        rsp_write_data;
   logic [cbcrtc_pkg::BYTE_W-1:0]        rsp_read_data;

   cbcrtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cbcrtc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_op           (req_tdata[1:0]),
      .req_addr         (req_tdata[17:2]),
      .req_data         (req_tdata[25:18]),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_access_kind  (rsp_access_kind),
      .rsp_phys_address (rsp_phys_address),
      .rsp_write_data   (rsp_write_data),
      .rsp_read_data    (rsp_read_data)
   );

   assign rsp_tdata = {rsp_read_data, rsp_write_data, rsp_phys_address, rsp_access_kind};

endmodule

`default_nettype wire

// File: hw/rtl/cbcrtc_mod.sv
// remainder unit for the rom bank number: upper bits before the register, lower bits after it
`default_nettype none

module cbcrtc_mod (
   input  wire logic                               clock,
   input  wire logic                               load,
   input  wire logic [cbcrtc_pkg::BANK_W-1:0]      dividend,
   input  wire logic [cbcrtc_pkg::COUNT_W-1:0]     divisor,
   output logic      [cbcrtc_pkg::BANK_W-1:0]      remainder
);

   logic [cbcrtc_pkg::COUNT_W-1:0]     part_ff, part_in;
   logic [cbcrtc_pkg::COUNT_W-1:0]     div_ff;
   logic [cbcrtc_pkg::MOD_LO_BITS-1:0] low_ff;
   logic [cbcrtc_pkg::COUNT_W-1:0]     rem_full;

   // one restoring step: shift in a dividend bit, subtract if it fits
   function automatic logic [cbcrtc_pkg::COUNT_W-1:0] mod_step(
      input logic [cbcrtc_pkg::COUNT_W-1:0] r,
      input logic                           b,
      input logic [cbcrtc_pkg::COUNT_W-1:0] d);
      logic [cbcrtc_pkg::COUNT_W-1:0] t;
      t = {r[cbcrtc_pkg::COUNT_W-2:0], b};
      if (t >= d) begin
         t = t - d;
      end
      return t;
   endfunction

   // upper dividend bits in the load cycle
   always_comb begin
      part_in = '0;
      for (int i = 0; i < cbcrtc_pkg::MOD_HI_BITS; i++) begin
         part_in = mod_step(part_in, dividend[cbcrtc_pkg::BANK_W-1-i], divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         part_ff <= part_in;
         div_ff  <= divisor;
         low_ff  <= dividend[cbcrtc_pkg::MOD_LO_BITS-1:0];
      end
   end

   // lower dividend bits in the following cycle
   always_comb begin
      rem_full = part_ff;
      for (int i = 0; i < cbcrtc_pkg::MOD_LO_BITS; i++) begin
         rem_full = mod_step(rem_full, low_ff[cbcrtc_pkg::MOD_LO_BITS-1-i], div_ff);
      end
   end

   assign remainder = rem_full[cbcrtc_pkg::BANK_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/cbcrtc_ctrl.sv
// controller state machine: input handshake, result register handshake
`default_nettype none
`include "cartridge_bank_controller_rtc_unit_macros.svh"

module cbcrtc_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output cbcrtc_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CALC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      slot_free;

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = valid_ff;
   assign slot_free    = !valid_ff || rsp_tready;
   assign cmd.load_in  = req_tvalid && req_tready;
   assign cmd.load_out = (state_ff == ST_CALC) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load_in) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   `CBC_ASSERT_NOW(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `CBC_ASSERT_NEXT(a_accept_to_calc, clock, reset, cmd.load_in, state_ff == ST_CALC,
                    "accepted transfer did not start calculation")
   `CBC_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_out, rsp_tvalid,
                    "loaded result not presented")
   `CBC_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_out && rsp_tvalid, rsp_tready,
                   "result overwritten before transfer")

endmodule

`default_nettype wire

// File: hw/rtl/cbcrtc_dp.sv
// datapath: mapper registers, rtc bytes, address mapping and result register
`default_nettype none
`include "cartridge_bank_controller_rtc_unit_macros.svh"

module cbcrtc_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire cbcrtc_pkg::cmd_type                   cmd,
   input  wire logic [cbcrtc_pkg::OP_W-1:0]           req_op,
   input  wire logic [cbcrtc_pkg::ADDR_W-1:0]         req_addr,
   input  wire logic [cbcrtc_pkg::BYTE_W-1:0]         req_data,
   input  wire logic                                  csr_we,
   input  wire logic [cbcrtc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cbcrtc_pkg::COUNT_W-1:0]        csr_wdata,
   output logic      [cbcrtc_pkg::KIND_W-1:0]         rsp_access_kind,
   output logic      [cbcrtc_pkg::PHYS_W-1:0]         rsp_phys_address,
   output logic      [cbcrtc_pkg::BYTE_W-1:0]         rsp_write_data,
   output logic      [cbcrtc_pkg::BYTE_W-1:0]         rsp_read_data
);

   // configuration
   logic                               has_ram_ff;
   logic                               has_rtc_ff;
   logic [cbcrtc_pkg::COUNT_W-1:0]     bank_count_ff;

   // mapper state
   logic                               ram_enabled_ff, ram_enabled_in;
   logic [cbcrtc_pkg::BANK_W-1:0]      rom_bank_ff, rom_bank_in;
   logic [cbcrtc_pkg::SEL_W-1:0]       window_sel_ff, window_sel_in;
   logic                               latch_ff, latch_in;
   logic [cbcrtc_pkg::BYTE_W-1:0]      rtc_live_ff    [cbcrtc_pkg::RTC_REGS];
   logic [cbcrtc_pkg::BYTE_W-1:0]      rtc_live_in    [cbcrtc_pkg::RTC_REGS];
   logic [cbcrtc_pkg::BYTE_W-1:0]      rtc_latched_ff [cbcrtc_pkg::RTC_REGS];
   logic [cbcrtc_pkg::BYTE_W-1:0]      rtc_latched_in [cbcrtc_pkg::RTC_REGS];

   // captured transfer
   logic [cbcrtc_pkg::OP_W-1:0]        op_ff;
   logic [cbcrtc_pkg::ADDR_W-1:0]      addr_ff;
   logic [cbcrtc_pkg::BYTE_W-1:0]      data_ff;

   // result register
   logic [cbcrtc_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [cbcrtc_pkg::PHYS_W-1:0]      phys_ff, phys_in;
   logic [cbcrtc_pkg::BYTE_W-1:0]      wdata_ff, wdata_in;
   logic [cbcrtc_pkg::BYTE_W-1:0]      rdata_ff, rdata_in;

   logic [cbcrtc_pkg::BANK_W-1:0]      mod_dividend;
   logic [cbcrtc_pkg::COUNT_W-1:0]     mod_divisor;
   logic [cbcrtc_pkg::BANK_W-1:0]      mod_rem;
   logic [cbcrtc_pkg::SEL_W-1:0]       sel_nibble;
   logic [cbcrtc_pkg::BANK_W-1:0]      bank_field;
   logic [cbcrtc_pkg::RTC_IDX_W-1:0]   rtc_wr_idx;
   logic [cbcrtc_pkg::RTC_IDX_W-1:0]   rtc_rd_idx;
   logic                               ram_mapped;
   logic                               rtc_mapped;
   logic [cbcrtc_pkg::RAM_SEL_W-1:0]   ram_bank;

   // bank 0 below 0x4000, else the bank register; a zero count acts as one
   assign mod_dividend = (req_addr[cbcrtc_pkg::ADDR_W-1:cbcrtc_pkg::ROM_OFF_W] == '0)
                         ? '0 : rom_bank_ff;
   assign mod_divisor  = (bank_count_ff == '0) ? cbcrtc_pkg::COUNT_W'(1) : bank_count_ff;

   cbcrtc_mod u_mod (
      .clock     (clock),
      .load      (cmd.load_in),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         has_ram_ff    <= 1'b1;
         has_rtc_ff    <= 1'b1;
         bank_count_ff <= 8'd128;
      end else if (csr_we) begin
         unique case (csr_index)
            cbcrtc_pkg::CSR_HAS_RAM:        has_ram_ff    <= csr_wdata[0];
            cbcrtc_pkg::CSR_HAS_RTC:        has_rtc_ff    <= csr_wdata[0];
            cbcrtc_pkg::CSR_ROM_BANK_COUNT: bank_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sel_nibble = req_data[cbcrtc_pkg::SEL_W-1:0];
   assign bank_field = req_data[cbcrtc_pkg::BANK_W-1:0];
   assign rtc_wr_idx = window_sel_ff[cbcrtc_pkg::RTC_IDX_W-1:0];

   // state updates take effect when the transfer is accepted
   always_comb begin
      ram_enabled_in = ram_enabled_ff;
      rom_bank_in    = rom_bank_ff;
      window_sel_in  = window_sel_ff;
      latch_in       = latch_ff;
      rtc_live_in    = rtc_live_ff;
      rtc_latched_in = rtc_latched_ff;
      if (cmd.load_in) begin
         if (req_op == cbcrtc_pkg::OP_CTRL_WRITE) begin
            unique case (req_addr[cbcrtc_pkg::ADDR_W-1:cbcrtc_pkg::RAM_OFF_W])
               cbcrtc_pkg::REGION_RAM_ENABLE: begin
                  ram_enabled_in = (req_data[3:0] == cbcrtc_pkg::RAM_ENABLE_KEY);
               end
               cbcrtc_pkg::REGION_ROM_BANK: begin
                  rom_bank_in = (bank_field == '0) ? cbcrtc_pkg::BANK_W'(1) : bank_field;
               end
               cbcrtc_pkg::REGION_WINDOW_SEL: begin
                  window_sel_in = (sel_nibble >= cbcrtc_pkg::SEL_MODULUS)
                                  ? sel_nibble - cbcrtc_pkg::SEL_MODULUS : sel_nibble;
               end
               cbcrtc_pkg::REGION_LATCH: begin
                  // with the clock present, a rising latch bit snapshots the live clock bytes
                  if (has_rtc_ff && !latch_ff && req_data[0]) begin
                     rtc_latched_in = rtc_live_ff;
                  end
                  latch_in = req_data[0];
               end
               default: ;
            endcase
         end else if (req_op == cbcrtc_pkg::OP_RAM_WRITE) begin
            if (ram_enabled_ff && has_rtc_ff && window_sel_ff >= cbcrtc_pkg::SEL_RTC_FIRST) begin
               rtc_live_in[rtc_wr_idx] = req_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enabled_ff <= 1'b0;
         rom_bank_ff    <= cbcrtc_pkg::BANK_W'(1);
         window_sel_ff  <= '0;
         latch_ff       <= 1'b0;
         for (int i = 0; i < cbcrtc_pkg::RTC_REGS; i++) begin
            rtc_live_ff[i]    <= '0;
            rtc_latched_ff[i] <= '0;
         end
      end else begin
         ram_enabled_ff <= ram_enabled_in;
         rom_bank_ff    <= rom_bank_in;
         window_sel_ff  <= window_sel_in;
         latch_ff       <= latch_in;
         rtc_live_ff    <= rtc_live_in;
         rtc_latched_ff <= rtc_latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff   <= req_op;
         addr_ff <= req_addr;
         data_ff <= req_data;
      end
   end

   // result of the captured transfer; reads and ram writes leave the window state alone
   assign ram_mapped = ram_enabled_ff && has_ram_ff && (window_sel_ff < cbcrtc_pkg::SEL_RAM_LIMIT);
   assign rtc_mapped = ram_enabled_ff && has_rtc_ff && (window_sel_ff >= cbcrtc_pkg::SEL_RTC_FIRST);
   assign ram_bank   = cbcrtc_pkg::ram_bank_of(window_sel_ff[cbcrtc_pkg::RAM_SEL_W-1:0]);
   assign rtc_rd_idx = window_sel_ff[cbcrtc_pkg::RTC_IDX_W-1:0];

   always_comb begin
      kind_in  = cbcrtc_pkg::KIND_NONE;
      phys_in  = '0;
      wdata_in = '0;
      rdata_in = '0;
      case (op_ff) inside
         cbcrtc_pkg::OP_ROM_READ: begin
            kind_in = cbcrtc_pkg::KIND_ROM_READ;
            phys_in = {mod_rem, addr_ff[cbcrtc_pkg::ROM_OFF_W-1:0]};
         end
         cbcrtc_pkg::OP_RAM_WRITE, cbcrtc_pkg::OP_RAM_READ: begin
            if (ram_mapped) begin
               phys_in = cbcrtc_pkg::PHYS_W'({ram_bank, addr_ff[cbcrtc_pkg::RAM_OFF_W-1:0]});
               if (op_ff == cbcrtc_pkg::OP_RAM_WRITE) begin
                  kind_in  = cbcrtc_pkg::KIND_RAM_WRITE;
                  wdata_in = data_ff;
               end else begin
                  kind_in = cbcrtc_pkg::KIND_RAM_READ;
               end
            end else if (rtc_mapped) begin
               if (op_ff == cbcrtc_pkg::OP_RAM_READ) begin
                  kind_in  = cbcrtc_pkg::KIND_RTC_READ;
                  rdata_in = rtc_latched_ff[rtc_rd_idx];
               end
            end else if (op_ff == cbcrtc_pkg::OP_RAM_READ) begin
               rdata_in = cbcrtc_pkg::OPEN_BUS_BYTE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         kind_ff  <= kind_in;
         phys_ff  <= phys_in;
         wdata_ff <= wdata_in;
         rdata_ff <= rdata_in;
      end
   end

   assign rsp_access_kind  = kind_ff;
   assign rsp_phys_address = phys_ff;
   assign rsp_write_data   = wdata_ff;
   assign rsp_read_data    = rdata_ff;

   `CBC_ASSERT_NOW(a_rom_bank_nonzero, clock, reset, 1'b1, rom_bank_ff != '0,
                   "rom bank register holds zero")
   `CBC_ASSERT_NOW(a_sel_in_range, clock, reset, 1'b1, window_sel_ff < cbcrtc_pkg::SEL_MODULUS,
                   "window select out of range")

endmodule

`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for the cartridge bank controller with clock registers
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbcrtc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 280;
   localparam int PHASES = 6;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      kind_type              kind;
      logic [PHYS_W-1:0]     phys;
      logic [BYTE_W-1:0]     wdata;
      logic [BYTE_W-1:0]     rdata;
   } bus_access_result;

   // tracks the bank registers and predicts the external access of every bus access
   class bank_map_checker;
      bus_access_result   expected_accesses[$];
      bit                 has_ram = 1'b1;
      bit                 has_rtc = 1'b1;
      logic [COUNT_W-1:0] bank_count = 8'd128;
      bit                 ram_en = 1'b0;
      logic [BANK_W-1:0]  rom_bank = 7'd1;
      logic [SEL_W-1:0]   win_sel = '0;
      bit                 latch = 1'b0;
      logic [BYTE_W-1:0]  rtc_live[RTC_REGS] = '{default: 8'h00};
      logic [BYTE_W-1:0]  rtc_held[RTC_REGS] = '{default: 8'h00};
      int                 fails = 0;

      function void write_csr(logic [CSR_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
         case (idx)
            CSR_HAS_RAM: has_ram = val[0];
            CSR_HAS_RTC: has_rtc = val[0];
            CSR_ROM_BANK_COUNT: bank_count = val;
            default: ;
         endcase
      endfunction

      function void note_access(op_type op, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
         bus_access_result res;
         int bank;
         int cnt;
         bit wr;
         bit done;
         res = '0;
         res.kind = KIND_NONE;
         case (op)
            OP_CTRL_WRITE: begin
               case (addr[15:13])
                  REGION_RAM_ENABLE: ram_en = (data[3:0] == RAM_ENABLE_KEY);
                  REGION_ROM_BANK: rom_bank = (data[6:0] == '0) ? 7'd1 : data[6:0];
                  REGION_WINDOW_SEL: win_sel = data[3:0] % SEL_MODULUS;
                  REGION_LATCH: begin
                     // only a rising latch bit snapshots the clock bytes
                     if (has_rtc && !latch && data[0])
                        rtc_held = rtc_live;
                     latch = data[0];
                  end
                  default: ;
               endcase
            end
            OP_ROM_READ: begin
               bank = (addr[15:14] == 2'b00) ? 0 : int'(rom_bank);
               cnt = (bank_count == '0) ? 1 : int'(bank_count);
               bank = bank % cnt;
               res.kind = KIND_ROM_READ;
               res.phys = PHYS_W'(bank * ROM_BANK_BYTES + int'(addr[13:0]));
            end
            default: begin
               wr = (op == OP_RAM_WRITE);
               done = 1'b0;
               if (ram_en) begin
                  if (win_sel < SEL_RAM_LIMIT && has_ram) begin
                     bank = int'(win_sel) % RAM_BANK_CNT;
                     res.phys = PHYS_W'(bank * RAM_BANK_BYTES + int'(addr[12:0]));
                     if (wr) begin
                        res.kind = KIND_RAM_WRITE;
                        res.wdata = data;
                     end else begin
                        res.kind = KIND_RAM_READ;
                     end
                     done = 1'b1;
                  end else if (has_rtc && win_sel >= SEL_RTC_FIRST) begin
                     if (wr) begin
                        rtc_live[win_sel - SEL_RTC_FIRST] = data;
                     end else begin
                        res.kind = KIND_RTC_READ;
                        res.rdata = rtc_held[win_sel - SEL_RTC_FIRST];
                     end
                     done = 1'b1;
                  end
               end
               if (!done && !wr)
                  res.rdata = OPEN_BUS_BYTE;
            end
         endcase
         expected_accesses.push_back(res);
      endfunction

      function void check_access(bus_access_result got);
         bus_access_result exp;
         if (expected_accesses.size() == 0) begin
            $error("result transfer with nothing expected: kind %0d phys %h", got.kind, got.phys);
            fails++;
            return;
         end
         exp = expected_accesses.pop_front();
         if (got.kind !== exp.kind) begin
            $error("access_kind expected %0d actual %0d", exp.kind, got.kind);
            fails++;
         end
         if (got.phys !== exp.phys) begin
            $error("phys_address expected %h actual %h", exp.phys, got.phys);
            fails++;
         end
         if (got.wdata !== exp.wdata) begin
            $error("write_data expected %h actual %h", exp.wdata, got.wdata);
            fails++;
         end
         if (got.rdata !== exp.rdata) begin
            $error("read_data expected %h actual %h", exp.rdata, got.rdata);
            fails++;
         end
      endfunction

      function int pending();
         return expected_accesses.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [COUNT_W-1:0]      csr_wdata = '0;

   bank_map_checker sb = new();
   bit req_fast = 1'b0;
   bit rsp_fast = 1'b0;
   int rsp_hold_cycles = 0;
   int quiet_cycles = 0;

   cartridge_bank_controller_rtc_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_access(op_type op, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
      int gap;
      gap = req_fast ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {6'b0, data, addr, op};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (sb.pending() > 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_csr(idx, val);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready = 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         gap = rsp_fast ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      bus_access_result got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = kind_type'(rsp_tdata[2:0]);
            got.phys = rsp_tdata[23:3];
            got.wdata = rsp_tdata[31:24];
            got.rdata = rsp_tdata[39:32];
            sb.check_access(got);
         end
         if (req_tvalid && req_tready)
            sb.note_access(op_type'(req_tdata[1:0]), req_tdata[17:2], req_tdata[25:18]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("cartridge_bank_controller_rtc_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      bit                 cfg_ram[PHASES] = '{1, 0, 1, 0, 1, 1};
      bit                 cfg_rtc[PHASES] = '{1, 1, 0, 0, 1, 1};
      logic [COUNT_W-1:0] cfg_count[PHASES] = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd3, 8'd128};
      int                 r;
      op_type             op;
      logic [ADDR_W-1:0]  a;
      logic [BYTE_W-1:0]  d;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: address extremes, bank zero, disabled and unmapped window, latch
      send_access(OP_ROM_READ, 16'h0000, 8'h00);
      send_access(OP_ROM_READ, 16'h3FFF, 8'hFF);
      send_access(OP_ROM_READ, 16'h4000, 8'h00);
      send_access(OP_ROM_READ, 16'hFFFF, 8'hFF);
      send_access(OP_CTRL_WRITE, 16'h2000, 8'h00);
      send_access(OP_CTRL_WRITE, 16'h3FFF, 8'hFF);
      send_access(OP_ROM_READ, 16'h7FFF, 8'h00);
      send_access(OP_RAM_READ, 16'hA000, 8'h00);
      send_access(OP_RAM_WRITE, 16'hBFFF, 8'h55);
      send_access(OP_CTRL_WRITE, 16'h1FFF, 8'hFA);
      send_access(OP_CTRL_WRITE, 16'h4000, 8'h03);
      send_access(OP_RAM_WRITE, 16'hFFFF, 8'hFF);
      send_access(OP_RAM_READ, 16'h0000, 8'h00);
      send_access(OP_CTRL_WRITE, 16'h5FFF, 8'h0F);
      send_access(OP_RAM_READ, 16'h1234, 8'h00);
      send_access(OP_CTRL_WRITE, 16'h4000, 8'h08);
      send_access(OP_RAM_WRITE, 16'h0000, 8'h5A);
      send_access(OP_CTRL_WRITE, 16'h4000, 8'hFC);
      send_access(OP_RAM_WRITE, 16'h0000, 8'hA5);
      send_access(OP_CTRL_WRITE, 16'h7FFF, 8'h01);
      send_access(OP_RAM_READ, 16'h0000, 8'h00);
      send_access(OP_CTRL_WRITE, 16'h4000, 8'h05);
      send_access(OP_RAM_READ, 16'h0000, 8'h00);
      send_access(OP_CTRL_WRITE, 16'h8000, 8'hFF);
      send_access(OP_CTRL_WRITE, 16'hFFFF, 8'h00);
      send_access(OP_CTRL_WRITE, 16'h0000, 8'h00);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         if (p == 4) begin
            cfg_ram[p] = $urandom_range(0, 1);
            cfg_rtc[p] = $urandom_range(0, 1);
            cfg_count[p] = $urandom_range(1, 128);
         end
         write_csr(CSR_HAS_RAM, COUNT_W'(cfg_ram[p]));
         write_csr(CSR_HAS_RTC, COUNT_W'(cfg_rtc[p]));
         write_csr(CSR_ROM_BANK_COUNT, cfg_count[p]);
         req_fast = (p == 1 || p == 2);
         rsp_fast = (p == 1 || p == 3);
         // fill the block while the result side is held off
         if (p == 2)
            rsp_hold_cycles = HOLD_OFF_CYCLES;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            r = $urandom_range(0, 99);
            a = ADDR_W'($urandom);
            d = BYTE_W'($urandom);
            if (r < 30) begin
               op = OP_CTRL_WRITE;
               // mostly the decoded regions, now and then the ignored upper half
               a[15] = ($urandom_range(0, 7) == 0);
               if (a[15:13] == REGION_RAM_ENABLE && $urandom_range(0, 1))
                  d[3:0] = RAM_ENABLE_KEY;
            end else if (r < 45) begin
               op = OP_ROM_READ;
            end else if (r < 72) begin
               op = OP_RAM_WRITE;
            end else begin
               op = OP_RAM_READ;
            end
            send_access(op, a, d);
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.fails == 0 && sb.pending() == 0)
         $display("cartridge_bank_controller_rtc_unit: match");
      else
         $display("cartridge_bank_controller_rtc_unit: mismatch");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/cbcrtc_pkg.sv
hw/rtl/cbcrtc_mod.sv
hw/rtl/cbcrtc_ctrl.sv
hw/rtl/cbcrtc_dp.sv
hw/rtl/cartridge_bank_controller_rtc_unit.sv
dv/tb.sv
